[rtl/core/rcf_pkg.sv]
// Shared types and constants for the ring color fader.
`default_nettype none
package rcf_pkg;

   // Default number of LED rings.
   localparam int RCF_RINGS_DEF = 6;
   localparam int RCF_MAX_RINGS = 6;

   // Divide by five through a reciprocal: (n * 205) >> 10 is exact for n < 256.
   localparam logic [7:0] RCF_FADE_RECIP = 8'd205;
   localparam int         RCF_FADE_SHIFT = 10;

   // LED span start of each ring, with the end of the last ring appended.
   localparam logic [7:0] RCF_SPAN_START [0:RCF_MAX_RINGS] = '{
      8'd0, 8'd8, 8'd24, 8'd48, 8'd80, 8'd116, 8'd160
   };

   // Operation of the shared arithmetic unit.
   typedef enum logic {
      RCF_OP_FADE,
      RCF_OP_SCALE
   } rcf_op_type;

   // Input transaction kinds.
   localparam logic RCF_KIND_SET  = 1'b0;
   localparam logic RCF_KIND_TICK = 1'b1;

endpackage : rcf_pkg
`default_nettype wire

[rtl/core/rcf_arith_unit.sv]
// Shared 8x8 multiplier unit: one fade step or one video scale per issue.
`default_nettype none
module rcf_arith_unit (
   input  wire logic              clock,
   input  wire logic              issue,
   input  wire rcf_pkg::rcf_op_type op,
   input  wire logic [7:0]        opnd_a,   // current level, or color channel
   input  wire logic [7:0]        opnd_b,   // target level, or brightness
   output logic [7:0]             result    // valid the cycle after issue
);
   import rcf_pkg::*;

   logic signed [8:0] diff;
   logic              neg;
   logic [7:0]        mag;
   logic [7:0]        mul_a;
   logic [7:0]        mul_b;

   logic [15:0] prod_ff;
   rcf_op_type  op_ff;
   logic [7:0]  base_ff;
   logic        neg_ff;
   logic        zero_ff;

   logic [5:0]  step;
   logic [7:0]  scaled;

   always_comb begin
      diff  = $signed({1'b0, opnd_b}) - $signed({1'b0, opnd_a});
      neg   = diff[8];
      mag   = neg ? 8'(-diff) : diff[7:0];
      mul_a = (op == RCF_OP_FADE) ? mag : opnd_a;
      mul_b = (op == RCF_OP_FADE) ? RCF_FADE_RECIP : opnd_b;
   end

   // Capture the product and what the finishing step needs.
   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff <= mul_a * mul_b;
         op_ff   <= op;
         base_ff <= opnd_a;
         neg_ff  <= neg;
         zero_ff <= (opnd_a == 8'd0) || (opnd_b == 8'd0);
      end
   end

   always_comb begin
      step   = prod_ff[15:RCF_FADE_SHIFT];
      scaled = prod_ff[15:8] + 8'd1;
      if (op_ff == RCF_OP_FADE) begin
         result = neg_ff ? (base_ff - {2'b00, step}) : (base_ff + {2'b00, step});
      end else begin
         result = zero_ff ? 8'd0 : scaled;
      end
   end

endmodule : rcf_arith_unit
`default_nettype wire

[rtl/core/ring_color_fader.sv]
// Ring color fader: per-ring color fade toward a target and brightness scaling.
//
// Usage
//   Input channel (req_*): a set-target transaction (kind 0) stores one ring's
//   target color and brightness, and with instant set copies it into the
//   current color too; it is taken while idle and returns nothing. Rings at
//   or beyond RINGS are dropped. A frame tick (kind 1) fades every channel of
//   every ring by one fifth of the remaining distance (truncated toward zero)
//   and then returns one rsp_* transaction per ring in ring order, with the
//   ring's LED span and its brightness-scaled color; rsp_last marks the final
//   ring of the tick.
//   Sequencing: one shared 8x8 multiplier does all arithmetic. Each ring needs
//   seven operations (four fades, three scales), each an issue state and a
//   write-back state, then an emit state that loads the output register.
//   req_stall stays high from the tick until the last ring's result is
//   loaded, so the next transaction is taken only after that. Receiver
//   stalls hold the emit state and add to this.
//   Reset clears all current and target levels and empties the output
//   register. When the receiver stalls, the result in the output register
//   holds and the sequencer waits before loading the next ring.
`default_nettype none
module ring_color_fader #(
   parameter int RINGS = rcf_pkg::RCF_RINGS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Input channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_kind,
   input  wire logic [2:0] req_ring,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic [7:0] req_brightness,
   input  wire logic       req_instant,
   // Result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_ring_index,
   output logic [7:0]      rsp_first_led,
   output logic [5:0]      rsp_led_count,
   output logic [7:0]      rsp_pixel_red,
   output logic [7:0]      rsp_pixel_green,
   output logic [7:0]      rsp_pixel_blue,
   output logic            rsp_last
);
   import rcf_pkg::*;

   localparam int RING_W = (RINGS > 1) ? $clog2(RINGS) : 1;
   localparam logic [RING_W-1:0] LAST_RING = RING_W'(RINGS - 1);

   // Operation order per ring: fade brightness, fade red, green, blue,
   // then scale red, green, blue.
   localparam logic [2:0] OP_FADE_BRT  = 3'd0;
   localparam logic [2:0] OP_FADE_LAST = 3'd3;
   localparam logic [2:0] OP_LAST      = 3'd6;
   localparam logic [1:0] CH_BRT       = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WB,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [RING_W-1:0] ring_ff;
   logic [2:0]        op_ff;
   logic [31:0]       cur_ff [RINGS];
   logic [31:0]       tgt_ff [RINGS];
   logic [7:0]        pix_ff [3];

   logic              rsp_valid_ff;
   logic [2:0]        rsp_ring_ff;
   logic [7:0]        rsp_first_ff;
   logic [5:0]        rsp_count_ff;
   logic [7:0]        rsp_red_ff;
   logic [7:0]        rsp_green_ff;
   logic [7:0]        rsp_blue_ff;
   logic              rsp_last_ff;

   logic              req_fire;
   logic              set_ok;
   logic [31:0]       req_packed;
   logic              is_fade;
   logic [1:0]        ch;
   rcf_op_type        unit_op;
   logic [7:0]        unit_a;
   logic [7:0]        unit_b;
   logic [7:0]        unit_res;
   logic              unit_issue;
   logic              out_free;
   logic              emit_load;
   logic [2:0]        ring_next;
   logic [7:0]        span_lo;
   logic [7:0]        span_hi;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign set_ok     = (req_ring < 3'(RINGS));
   assign req_packed = {req_brightness, req_blue, req_green, req_red};
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_load  = (state_ff == ST_EMIT) && out_free;

   // Channel under work for the current operation.
   always_comb begin
      is_fade = (op_ff <= OP_FADE_LAST);
      if (op_ff == OP_FADE_BRT) begin
         ch = CH_BRT;
      end else if (is_fade) begin
         ch = 2'(op_ff - 3'd1);
      end else begin
         ch = 2'(op_ff - 3'd4);
      end
   end

   // Operand select for the shared unit; scaling uses the freshly faded values.
   always_comb begin
      unit_issue = (state_ff == ST_ISSUE);
      unit_op    = is_fade ? RCF_OP_FADE : RCF_OP_SCALE;
      unit_a     = cur_ff[ring_ff][8*ch +: 8];
      unit_b     = is_fade ? tgt_ff[ring_ff][8*ch +: 8] : cur_ff[ring_ff][31:24];
   end

   rcf_arith_unit u_arith (
      .clock  (clock),
      .issue  (unit_issue),
      .op     (unit_op),
      .opnd_a (unit_a),
      .opnd_b (unit_b),
      .result (unit_res)
   );

   assign ring_next = 3'(ring_ff) + 3'd1;
   assign span_lo   = RCF_SPAN_START[3'(ring_ff)];
   assign span_hi   = RCF_SPAN_START[ring_next];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ring_ff      <= '0;
         op_ff        <= OP_FADE_BRT;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RINGS; i++) begin
            cur_ff[i] <= '0;
            tgt_ff[i] <= '0;
         end
      end else begin
         // Load a new ring result, or drop the held one once taken.
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_kind == RCF_KIND_TICK) begin
                     ring_ff  <= '0;
                     op_ff    <= OP_FADE_BRT;
                     state_ff <= ST_ISSUE;
                  end else if (set_ok) begin
                     tgt_ff[req_ring[RING_W-1:0]] <= req_packed;
                     if (req_instant) begin
                        cur_ff[req_ring[RING_W-1:0]] <= req_packed;
                     end
                  end
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_WB;
            end
            ST_WB: begin
               if (is_fade) begin
                  cur_ff[ring_ff][8*ch +: 8] <= unit_res;
               end else begin
                  pix_ff[ch] <= unit_res;
               end
               if (op_ff == OP_LAST) begin
                  state_ff <= ST_EMIT;
               end else begin
                  op_ff    <= op_ff + 3'd1;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_EMIT: begin
               // Hold until the output register is free, then load this ring.
               if (out_free) begin
                  rsp_ring_ff  <= 3'(ring_ff);
                  rsp_first_ff <= span_lo;
                  rsp_count_ff <= 6'(span_hi - span_lo);
                  rsp_red_ff   <= pix_ff[0];
                  rsp_green_ff <= pix_ff[1];
                  rsp_blue_ff  <= pix_ff[2];
                  rsp_last_ff  <= (ring_ff == LAST_RING);
                  op_ff        <= OP_FADE_BRT;
                  if (ring_ff == LAST_RING) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     ring_ff  <= ring_ff + RING_W'(1);
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ring_index  = rsp_ring_ff;
   assign rsp_first_led   = rsp_first_ff;
   assign rsp_led_count   = rsp_count_ff;
   assign rsp_pixel_red   = rsp_red_ff;
   assign rsp_pixel_green = rsp_green_ff;
   assign rsp_pixel_blue  = rsp_blue_ff;
   assign rsp_last        = rsp_last_ff;

   // A tick takes the block busy on the next cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_kind == RCF_KIND_TICK) |=> req_stall)
      else $error("tick accepted but block did not go busy");

   // A set-target transaction leaves the block ready.
   a_set_ready: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_kind == RCF_KIND_SET) |=> !req_stall)
      else $error("set-target transaction made the block busy");

   // Every write-back follows an issue to the shared unit.
   a_wb_after_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB) |-> ($past(state_ff) == ST_ISSUE))
      else $error("write-back without issue");

   // A result always names a ring that exists.
   a_ring_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ring_index < 3'(RINGS)))
      else $error("result ring index out of range");

endmodule : ring_color_fader
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for ring_color_fader: directed table, random traffic, scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rcf_pkg::*;

   localparam int NUM_RINGS      = 6;
   localparam int DIR_ROWS       = 20;
   localparam int RANDOM_ITEMS   = 100;   // transactions that touch state
   localparam int IDLE_PCT       = 30;    // chance of an idle cycle on either side
   localparam int HOLD_CYCLES    = 400;   // one long receiver hold-off
   localparam int DRAIN_CYCLES   = 120;   // idle wait after the last owed result
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction on either side
   localparam int REPORT_MAX     = 10;

   // One ring result as it leaves the block.
   typedef struct packed {
      logic [2:0] ring_index;
      logic [7:0] first_led;
      logic [5:0] led_count;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } ring_pixel_type;

   // One input transaction; known/level type in the pixel value of every ring
   // for ticks whose outcome is obvious.
   typedef struct packed {
      logic       kind;
      logic [2:0] ring;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] brightness;
      logic       instant;
      logic       known;
      logic [7:0] level;
   } fader_cmd_type;

   // Channel index within a ring's level.
   localparam int CH_RED = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE = 2;
   localparam int CH_BRIGHT = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic       req_kind       = RCF_KIND_SET;
   logic [2:0] req_ring       = 3'd0;
   logic [7:0] req_red        = 8'd0;
   logic [7:0] req_green      = 8'd0;
   logic [7:0] req_blue       = 8'd0;
   logic [7:0] req_brightness = 8'd0;
   logic       req_instant    = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [2:0] rsp_ring_index;
   logic [7:0] rsp_first_led;
   logic [5:0] rsp_led_count;
   logic [7:0] rsp_pixel_red;
   logic [7:0] rsp_pixel_green;
   logic [7:0] rsp_pixel_blue;
   logic       rsp_last;

   ring_color_fader #(.RINGS(NUM_RINGS)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_ring        (req_ring),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_brightness  (req_brightness),
      .req_instant     (req_instant),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ring_index  (rsp_ring_index),
      .rsp_first_led   (rsp_first_led),
      .rsp_led_count   (rsp_led_count),
      .rsp_pixel_red   (rsp_pixel_red),
      .rsp_pixel_green (rsp_pixel_green),
      .rsp_pixel_blue  (rsp_pixel_blue),
      .rsp_last        (rsp_last)
   );

   always #1 clock = ~clock;

   // Shadow copy of the fader state: current and target level per ring and channel.
   logic [7:0] cur_level [NUM_RINGS][4];
   logic [7:0] tgt_level [NUM_RINGS][4];

   // Ring results still owed by the block, oldest first.
   ring_pixel_type pixels_owed [$];

   fader_cmd_type dir_table [0:DIR_ROWS-1];

   int  mismatches   = 0;
   int  n_txn        = 0;
   int  n_ticks      = 0;
   int  n_targets    = 0;
   int  n_dropped    = 0;
   int  n_pixels     = 0;
   int  quiet_cycles = 0;
   bit  hold_request = 1'b0;
   bit  rsp_quiet    = 1'b0;

   // LED span start of each ring; index NUM_RINGS is the end of the last ring.
   function automatic logic [7:0] span_start(input int z);
      case (z)
         0: span_start = 8'd0;
         1: span_start = 8'd8;
         2: span_start = 8'd24;
         3: span_start = 8'd48;
         4: span_start = 8'd80;
         5: span_start = 8'd116;
         default: span_start = 8'd160;
      endcase
   endfunction

   // Move one fifth of the way toward the target, truncated toward zero.
   function automatic logic [7:0] fade_toward(input logic [7:0] cur, input logic [7:0] tgt);
      int d;
      d = int'(tgt) - int'(cur);
      fade_toward = 8'(int'(cur) + d / 5);
   endfunction

   // Video scaling: a lit channel never drops to zero.
   function automatic logic [7:0] video_scale(input logic [7:0] c, input logic [7:0] s);
      logic [15:0] prod;
      prod = c * s;
      if (c == 8'd0) video_scale = 8'd0;
      else video_scale = prod[15:8] + 8'd1;
   endfunction

   // Store a ring's target; out-of-range rings are dropped.
   task automatic store_target(input fader_cmd_type c);
      logic [7:0] lvl [4];
      int k;
      lvl[CH_RED] = c.red;
      lvl[CH_GREEN] = c.green;
      lvl[CH_BLUE] = c.blue;
      lvl[CH_BRIGHT] = c.brightness;
      if (c.ring >= NUM_RINGS) begin
         n_dropped++;
      end else begin
         n_targets++;
         for (k = 0; k < 4; k++) begin
            tgt_level[c.ring][k] = lvl[k];
            if (c.instant) cur_level[c.ring][k] = lvl[k];
         end
      end
   endtask

   // Fade every ring, then queue the six ring results of the tick.
   task automatic run_frame_tick(input fader_cmd_type c);
      ring_pixel_type px;
      logic [7:0]  s;
      int z;
      int k;
      n_ticks++;
      for (z = 0; z < NUM_RINGS; z++)
         for (k = 0; k < 4; k++)
            cur_level[z][k] = fade_toward(cur_level[z][k], tgt_level[z][k]);
      for (z = 0; z < NUM_RINGS; z++) begin
         s = cur_level[z][CH_BRIGHT];
         px.ring_index = 3'(z);
         px.first_led = span_start(z);
         px.led_count = 6'(span_start(z + 1) - span_start(z));
         if (c.known) begin
            px.red = c.level;
            px.green = c.level;
            px.blue = c.level;
         end else if (s != 8'd0) begin
            px.red = video_scale(cur_level[z][CH_RED], s);
            px.green = video_scale(cur_level[z][CH_GREEN], s);
            px.blue = video_scale(cur_level[z][CH_BLUE], s);
         end else begin
            px.red = 8'd0;
            px.green = 8'd0;
            px.blue = 8'd0;
         end
         px.last = (z == NUM_RINGS - 1);
         pixels_owed.push_back(px);
      end
   endtask

   // Offer one transaction: random idle cycles first unless quiet, then hold the payload
   // until the block takes it, then advance the shadow model.
   task automatic offer(input fader_cmd_type c, input bit quiet);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= c.kind;
      req_ring       <= c.ring;
      req_red        <= c.red;
      req_green      <= c.green;
      req_blue       <= c.blue;
      req_brightness <= c.brightness;
      req_instant    <= c.instant;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_txn++;
      if (c.kind == RCF_KIND_TICK) run_frame_tick(c);
      else store_target(c);
   endtask

   // Bias toward the channel extremes and tiny values that fade by zero.
   function automatic logic [7:0] rand_level();
      case ($urandom_range(0, 7))
         0: rand_level = 8'd0;
         1: rand_level = 8'd255;
         2: rand_level = 8'($urandom_range(1, 5));
         default: rand_level = 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic fader_cmd_type rand_cmd();
      fader_cmd_type c;
      c.kind = ($urandom_range(0, 3) == 0) ? RCF_KIND_TICK : RCF_KIND_SET;
      c.ring = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
      c.red = rand_level();
      c.green = rand_level();
      c.blue = rand_level();
      c.brightness = rand_level();
      c.instant = ($urandom_range(0, 2) == 0);
      c.known = 1'b0;
      c.level = 8'd0;
      rand_cmd = c;
   endfunction

   // Result side: check each accepted transaction against the oldest owed
   // result, then pick next cycle's stall. Values read here are pre-edge.
   ring_pixel_type got_px;
   ring_pixel_type want_px;
   int          hold_left = 0;
   bit          hold_started = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_pixels++;
            got_px = '{rsp_ring_index, rsp_first_led, rsp_led_count, rsp_pixel_red,
                       rsp_pixel_green, rsp_pixel_blue, rsp_last};
            if (pixels_owed.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected ring result: ring %0d led %0d+%0d rgb %h %h %h last %b",
                           got_px.ring_index, got_px.first_led, got_px.led_count,
                           got_px.red, got_px.green, got_px.blue, got_px.last);
            end else begin
               want_px = pixels_owed.pop_front();
               if (got_px !== want_px) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("ring result mismatch: expected ring %0d led %0d+%0d rgb %h %h %h last %b",
                              want_px.ring_index, want_px.first_led, want_px.led_count,
                              want_px.red, want_px.green, want_px.blue, want_px.last);
                     $display("                      actual   ring %0d led %0d+%0d rgb %h %h %h last %b",
                              got_px.ring_index, got_px.first_led, got_px.led_count,
                              got_px.red, got_px.green, got_px.blue, got_px.last);
                  end
               end
            end
         end
         // Start the one long hold-off when the random phase begins, so the
         // block fills up and stalls its input while the sender keeps offering.
         if (hold_request && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         // A run of results with no stalls at all.
         rsp_quiet = (n_pixels >= 90 && n_pixels < 180);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // Watchdog: end the run if neither side moves a transaction for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      int i;
      int z;
      int k;
      int useful;
      fader_cmd_type c;

      // Shadow state after reset: everything dark.
      for (z = 0; z < NUM_RINGS; z++)
         for (k = 0; k < 4; k++) begin
            cur_level[z][k] = 8'd0;
            tgt_level[z][k] = 8'd0;
         end

      // kind, ring, red, green, blue, brightness, instant, known, level
      dir_table = '{
         // tick straight after reset: every ring black
         '{RCF_KIND_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00},
         // every ring jumps to full white at full brightness
         '{RCF_KIND_SET,  3'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'h00},
         '{RCF_KIND_SET,  3'd1, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'h00},
         '{RCF_KIND_SET,  3'd2, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'h00},
         '{RCF_KIND_SET,  3'd3, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'h00},
         '{RCF_KIND_SET,  3'd4, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'h00},
         '{RCF_KIND_SET,  3'd5, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'h00},
         // at target already: 255 scaled by 255 stays 255
         '{RCF_KIND_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'hff},
         // rings past the end are dropped
         '{RCF_KIND_SET,  3'd6, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00},
         '{RCF_KIND_SET,  3'd7, 8'haa, 8'h55, 8'haa, 8'h55, 1'b1, 1'b0, 8'h00},
         '{RCF_KIND_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'hff},
         // target only: current stays and fades down over the ticks
         '{RCF_KIND_SET,  3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
         // lowest brightness with a one, a zero and a full channel
         '{RCF_KIND_SET,  3'd5, 8'h01, 8'h00, 8'hff, 8'h01, 1'b1, 1'b0, 8'h00},
         // zero brightness blanks a lit color
         '{RCF_KIND_SET,  3'd2, 8'h80, 8'h40, 8'h20, 8'h00, 1'b1, 1'b0, 8'h00},
         '{RCF_KIND_SET,  3'd3, 8'h00, 8'hff, 8'h80, 8'h80, 1'b0, 1'b0, 8'h00},
         '{RCF_KIND_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
         '{RCF_KIND_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
         '{RCF_KIND_SET,  3'd4, 8'hff, 8'h00, 8'hff, 8'hff, 1'b0, 1'b0, 8'h00},
         '{RCF_KIND_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
         // tick with every other field at ones: those fields are don't-care
         '{RCF_KIND_TICK, 3'd7, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'h00}
      };

      // Synchronous reset, held at the start and never asserted again.
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) offer(dir_table[i], 1'b0);

      // Random phase: open with a tick so the receiver hold-off has results to
      // back up, then a random mix of ticks and targets, with some dropped rings.
      hold_request = 1'b1;
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         c = rand_cmd();
         if (useful == 0) c.kind = RCF_KIND_TICK;
         // sender goes without idle cycles for a stretch
         offer(c, (useful >= 40 && useful < 70));
         if (!(c.kind == RCF_KIND_SET && c.ring >= NUM_RINGS)) useful++;
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed result, then let a full tick's worth of
      // cycles pass so a stray extra result would still be caught.
      while (pixels_owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pixels_owed.size() != 0) begin
         mismatches += pixels_owed.size();
         $display("%0d ring results never arrived", pixels_owed.size());
      end

      $display("covered %0d transactions: %0d frame ticks, %0d target writes, %0d dropped rings",
               n_txn, n_ticks, n_targets, n_dropped);
      $display("checked %0d ring results, %0d mismatches", n_pixels, mismatches);
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
